// File: design/dtps_pkg.sv
// shared constants and types for the dual tap pitch shifter
package dtps_pkg;

    localparam int DTPS_RING_DEPTH    = 1024;
    localparam int DTPS_FRACTION_BITS = 16;

    localparam int SAMPLE_W = 24;
    localparam int STEP_W   = 18;
    localparam int WIN_W    = 16;

    localparam logic [STEP_W-1:0] PITCH_RESET = STEP_W'(65536);
    localparam logic [63:0]       PI_Q30      = 64'd3373259426;

    // control word from the sequencer to the shared multiply unit
    typedef struct packed {
        logic start;
        logic fade;
    } mac_ctrl_t;

endpackage

// File: design/dual_tap_pitch_shifter_unit.sv
// top level: ring sequencer, read pointer, tap interpolation and crossfade
// a sample is written to the ring, four taps are read and interpolated and crossfaded in
//   the shared multiplier; one sample at a time, as set by the single-port ring ram
//   (one write and four reads per sample) and three passes through the shared multiplier
// reset: pointers clear, pitch_step returns to 65536; the ring is not swept,
//   write tracking makes never-written entries read as zero, so no clearing pass
module dual_tap_pitch_shifter_unit
    import dtps_pkg::*;
#(
    parameter int RING_DEPTH    = DTPS_RING_DEPTH,
    parameter int FRACTION_BITS = DTPS_FRACTION_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [STEP_W-1:0]   cfg_wdata,       // pitch_step
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,    // [23:0] sample_in
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata     // [23:0] sample_out
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int PW    = AW + FRACTION_BITS;
    localparam int MW    = (FRACTION_BITS > WIN_W) ? FRACTION_BITS : WIN_W;
    localparam int SH_L  = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
    localparam int SH_R  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam int SW    = STEP_W + SH_L;
    localparam logic [AW-1:0] HALF = AW'(RING_DEPTH / 2);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WRITE  = 4'd1;
    localparam logic [3:0] ST_RD_I   = 4'd2;
    localparam logic [3:0] ST_RD_I1  = 4'd3;
    localparam logic [3:0] ST_RD_J   = 4'd4;
    localparam logic [3:0] ST_RD_J1  = 4'd5;
    localparam logic [3:0] ST_TAP2   = 4'd6;
    localparam logic [3:0] ST_WAIT   = 4'd7;
    localparam logic [3:0] ST_X4     = 4'd8;
    localparam logic [3:0] ST_FADE   = 4'd9;
    localparam logic [3:0] ST_FWAIT  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       wr_idx_reg;
    logic [PW-1:0]       pos_reg;
    logic [STEP_W-1:0]   pitch_reg;
    logic                started_reg;
    logic                full_reg;
    logic                rd_ok_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] a0_reg;
    logic signed [SAMPLE_W-1:0] a1_reg;
    logic signed [SAMPLE_W-1:0] x3_reg;
    logic signed [SAMPLE_W-1:0] x4_reg;

    logic                       in_xfer;
    logic [SW-1:0]              step_wide;
    logic [PW-1:0]              step_scaled;
    logic [AW-1:0]              idx_i, idx_i1, idx_j, idx_j1, hann_addr;
    logic [FRACTION_BITS-1:0]   frac;
    logic                       ram_en, ram_we;
    logic [AW-1:0]              ram_addr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic                       addr_ok;
    logic [WIN_W-1:0]           win;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_W-1:0] mac_base, mac_other, mac_result;
    logic [MW-1:0]              mac_weight;
    logic                       out_free;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // pitch step rescaled to the fraction width
    assign step_wide   = SW'(pitch_reg) << SH_L;
    assign step_scaled = PW'(step_wide >> SH_R);

    // tap addresses from the updated read position
    assign idx_i     = pos_reg[PW-1:FRACTION_BITS];
    assign frac      = pos_reg[FRACTION_BITS-1:0];
    assign idx_i1    = idx_i + AW'(1);
    assign idx_j     = idx_i1 + HALF;
    assign idx_j1    = idx_j + AW'(1);
    assign hann_addr = idx_i1 - wr_idx_reg;

    // entries never written read as zero
    assign addr_ok = full_reg || (started_reg && (ram_addr >= wr_idx_reg));
    assign rd_data = rd_ok_reg ? $signed(ram_rdata) : '0;

    // ring access per state
    always_comb
    begin
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = idx_i;
        unique case (state_reg)
            ST_WRITE:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = wr_idx_reg;
            end
            ST_RD_I:
            begin
                ram_en   = 1'b1;
                ram_addr = idx_i;
            end
            ST_RD_I1:
            begin
                ram_en   = 1'b1;
                ram_addr = idx_i1;
            end
            ST_RD_J:
            begin
                ram_en   = 1'b1;
                ram_addr = idx_j;
            end
            ST_RD_J1:
            begin
                ram_en   = 1'b1;
                ram_addr = idx_j1;
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    // shared multiplier operands per state
    always_comb
    begin
        mac_ctrl   = '0;
        mac_base   = a0_reg;
        mac_other  = rd_data;
        mac_weight = MW'(frac);
        unique case (state_reg)
            ST_RD_J:
            begin
                mac_ctrl.start = 1'b1;
            end
            ST_TAP2:
            begin
                mac_ctrl.start = 1'b1;
                mac_base       = a1_reg;
            end
            ST_FADE:
            begin
                mac_ctrl.start = 1'b1;
                mac_ctrl.fade  = 1'b1;
                mac_base       = x4_reg;
                mac_other      = x3_reg;
                mac_weight     = MW'(win);
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = in_xfer ? ST_WRITE : ST_IDLE;
            ST_WRITE: state_next = ST_RD_I;
            ST_RD_I:  state_next = ST_RD_I1;
            ST_RD_I1: state_next = ST_RD_J;
            ST_RD_J:  state_next = ST_RD_J1;
            ST_RD_J1: state_next = ST_TAP2;
            ST_TAP2:  state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_X4;
            ST_X4:    state_next = ST_FADE;
            ST_FADE:  state_next = ST_FWAIT;
            ST_FWAIT: state_next = ST_OUT;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state, pointers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            pos_reg       <= '0;
            pitch_reg     <= PITCH_RESET;
            started_reg   <= 1'b0;
            full_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_ok_reg <= addr_ok;
            if (cfg_we)
            begin
                pitch_reg <= cfg_wdata;
            end
            if (in_xfer)
            begin
                wr_idx_reg <= wr_idx_reg - AW'(1);
                pos_reg    <= pos_reg - step_scaled;
            end
            if (state_reg == ST_WRITE)
            begin
                started_reg <= 1'b1;
                if (wr_idx_reg == '0)
                begin
                    full_reg <= 1'b1;
                end
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample path registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= s_axis_tdata;
        end
        if (state_reg == ST_RD_I1)
        begin
            a0_reg <= rd_data;
        end
        if (state_reg == ST_RD_J1)
        begin
            a1_reg <= rd_data;
        end
        if (state_reg == ST_TAP2)
        begin
            x3_reg <= mac_result;
        end
        if (state_reg == ST_X4)
        begin
            x4_reg <= mac_result;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg <= mac_result;
        end
    end

    dtps_ram
    #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    )
    u_ring
    (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    dtps_hann_rom
    #(
        .DEPTH (RING_DEPTH)
    )
    u_hann
    (
        .clk  (clk),
        .addr (hann_addr),
        .win  (win)
    );

    dtps_mac
    #(
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_mac
    (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .base   (mac_base),
        .other  (mac_other),
        .weight (mac_weight),
        .result (mac_result)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// File: design/dtps_ram.sv
// generic single-port ram with registered read
module dtps_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, write or read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dtps_hann_rom.sv
// hann window table, built at elaboration, registered read
module dtps_hann_rom
    import dtps_pkg::*;
#(
    parameter int DEPTH = DTPS_RING_DEPTH
)
(
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [WIN_W-1:0]         win
);

    logic [WIN_W-1:0] rom [DEPTH];
    logic [WIN_W-1:0] win_reg;

    // sin^2 by a fixed-point taylor series, angle folded into the first quadrant
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] M  = (k <= DEPTH - k) ? 64'(k) : 64'(DEPTH - k);
        localparam logic [63:0] X  = (PI_Q30 * M) / 64'(DEPTH);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
        localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
                                           - $signed(T3) + $signed(T4) - $signed(T5)
                                           + $signed(T6);
        localparam logic [63:0] S  = (SUM < 0) ? 64'd0 :
                                     ((SUM > 64'sh7FFFFFFF) ? 64'h7FFFFFFF : 64'(SUM));
        localparam logic [63:0] SQ = S * S;
        localparam logic [63:0] W  = (SQ + (64'd1 << 44)) >> 45;
        localparam logic [63:0] WV = (W > 64'd32768) ? 64'd32768 : W;

        assign rom[k] = WIN_W'(WV);
    end

    // registered table read
    always_ff @(posedge clk)
    begin
        win_reg <= rom[addr];
    end

    assign win = win_reg;

endmodule

// File: design/dtps_mac.sv
// shared two-stage multiply unit: base + round((other - base) * weight / 2^shift)
module dtps_mac
    import dtps_pkg::*;
#(
    parameter int FRACTION_BITS = DTPS_FRACTION_BITS
)
(
    input  logic                                clk,
    input  mac_ctrl_t                           ctrl,
    input  logic signed [SAMPLE_W-1:0]          base,
    input  logic signed [SAMPLE_W-1:0]          other,
    input  logic [((FRACTION_BITS > WIN_W) ? FRACTION_BITS : WIN_W)-1:0] weight,
    output logic signed [SAMPLE_W-1:0]          result
);

    localparam int MW  = (FRACTION_BITS > WIN_W) ? FRACTION_BITS : WIN_W;
    localparam int DW  = SAMPLE_W + 1;
    localparam int PRW = DW + MW + 1;

    logic signed [SAMPLE_W-1:0] base_reg;
    logic signed [DW-1:0]       diff_reg;
    logic [MW-1:0]              wt_reg;
    logic                       fade_reg;

    logic signed [SAMPLE_W-1:0] base_p_reg;
    logic signed [PRW-1:0]      prod_reg;
    logic                       fade_p_reg;

    logic signed [PRW-1:0] rnd_frac;
    logic signed [PRW-1:0] rnd_fade;
    logic signed [PRW-1:0] acc;

    // operand stage, loaded on start
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            base_reg <= base;
            diff_reg <= DW'(other) - DW'(base);
            wt_reg   <= weight;
            fade_reg <= ctrl.fade;
        end
    end

    // product stage
    always_ff @(posedge clk)
    begin
        base_p_reg <= base_reg;
        prod_reg   <= PRW'(diff_reg) * $signed({1'b0, wt_reg});
        fade_p_reg <= fade_reg;
    end

    // round half up and add back the base
    assign rnd_frac = (prod_reg + (PRW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    assign rnd_fade = (prod_reg + (PRW'(1) <<< (WIN_W - 2))) >>> (WIN_W - 1);
    assign acc      = PRW'(base_p_reg) + (fade_p_reg ? rnd_fade : rnd_frac);
    assign result   = acc[SAMPLE_W-1:0];

endmodule

// File: design/dtps_checker.sv
// port-level checks for the pitch shifter, bound to the top level
module dtps_checker
    import dtps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [SAMPLE_W-1:0] m_axis_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // an input transfer makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in work");

    // a new result appears only out of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a sample in work");

endmodule

bind dual_tap_pitch_shifter_unit dtps_checker u_dtps_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the dual tap pitch shifter with its own predictor
module tb_top;
    import dtps_pkg::*;

    localparam int DEPTH   = DTPS_RING_DEPTH;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int FB      = DTPS_FRACTION_BITS;
    localparam int POS_W   = IDX_W + FB;
    localparam longint FRAC_ONE = longint'(1) << FB;
    localparam longint WIN_ONE  = 32768;
    localparam int PHASE_ITEMS  = 118;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [STEP_W-1:0]   cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;

    // predictor state
    logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];
    logic [WIN_W-1:0]           window_rom [DEPTH];
    logic [IDX_W-1:0]           wr_ptr;
    logic [POS_W-1:0]           rd_pos;
    logic [STEP_W-1:0]          step_reg;

    // stimulus and checking bookkeeping
    logic [SAMPLE_W-1:0] sample_queue [$];
    logic [SAMPLE_W-1:0] expected_out [$];
    int  inputs_left = 0;
    int  error_count = 0;
    int  samples_sent = 0;
    int  results_checked = 0;
    int  pitch_settings = 0;
    int  idle_left = 0;
    int  stall_left = 0;
    bit  in_taken = 1'b0;
    bit  burst_mode = 1'b0;

    dual_tap_pitch_shifter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // squared sine window entry, Q1.15, from a fixed-point Taylor series
    function automatic logic [WIN_W-1:0] hann_weight(int k);
        longint unsigned m, x, x2, term, s, sq, wv;
        longint sum;
        m = (k <= DEPTH - k) ? k : DEPTH - k;
        x = (PI_Q30 * m) / DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        s = sum;
        if (s > 64'h7FFF_FFFF)
            s = 64'h7FFF_FFFF;
        sq = s * s;
        wv = (sq + (longint'(1) << 44)) >> 45;
        if (wv > 32768)
            wv = 32768;
        return wv[WIN_W-1:0];
    endfunction

    // weighted two-point mix with round half up
    function automatic longint blend(longint a, longint b, longint wb, longint one, int sh);
        return (a * (one - wb) + b * wb + (one >>> 1)) >>> sh;
    endfunction

    // store the sample, move the read pointer, interpolate both taps and crossfade
    function automatic logic [SAMPLE_W-1:0] shift_pitch(logic [SAMPLE_W-1:0] raw);
        longint scaled, frac, tap_a, tap_b, mix;
        logic [IDX_W-1:0] i, j;
        wr_ptr = wr_ptr - 1'b1;
        ring_mem[wr_ptr] = raw;
        if (FB >= 16)
            scaled = longint'(step_reg) << (FB - 16);
        else
            scaled = longint'(step_reg) >> (16 - FB);
        rd_pos = rd_pos - POS_W'(scaled);
        i = rd_pos[POS_W-1 -: IDX_W];
        frac = longint'(rd_pos[FB-1:0]);
        tap_a = blend(ring_mem[i], ring_mem[IDX_W'(i + 1)], frac, FRAC_ONE, FB);
        j = IDX_W'(i + 1 + DEPTH / 2);
        tap_b = blend(ring_mem[j], ring_mem[IDX_W'(j + 1)], frac, FRAC_ONE, FB);
        mix = blend(tap_b, tap_a, longint'(window_rom[IDX_W'(i + 1 - wr_ptr)]), WIN_ONE, 15);
        return mix[SAMPLE_W-1:0];
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return SAMPLE_W'($urandom);
        else if (r < 70)
            return SAMPLE_W'($urandom_range(0, 512) - 256);
        else if (r < 85)
            case ($urandom_range(0, 3))
                0: return 24'h7FFFFF;
                1: return 24'h800000;
                2: return 24'hFFFFFF;
                default: return 24'h000000;
            endcase
        else
            return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 22'($urandom)};
    endfunction

    task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] want,
                                   logic [SAMPLE_W-1:0] got);
        error_count++;
        $display("%0t: %s: expected %06h, got %06h", $realtime, what, want, got);
    endtask

    task automatic queue_sample(logic [SAMPLE_W-1:0] v);
        sample_queue.push_back(v);
        inputs_left++;
    endtask

    // hold off until every transfer is taken and every result has come back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (inputs_left != 0 || expected_out.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_pitch(logic [STEP_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pitch_settings++;
    endtask

    // input side driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            idle_left = 0;
        end
        else if (s_axis_tvalid && !in_taken)
        begin
            // transfer still pending
        end
        else if (idle_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            idle_left--;
        end
        else if (sample_queue.size() > 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= sample_queue.pop_front();
            idle_left = burst_mode ? 0 : pick_gap();
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // output side backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!burst_mode && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // monitor: track config, predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken = 1'b0;
            step_reg = PITCH_RESET;
            wr_ptr   = '0;
            rd_pos   = '0;
            for (int k = 0; k < DEPTH; k++)
            begin
                ring_mem[k]   = '0;
                window_rom[k] = hann_weight(k);
            end
        end
        else
        begin
            if (cfg_we)
                step_reg = cfg_wdata;
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken)
            begin
                expected_out.push_back(shift_pitch(s_axis_tdata));
                inputs_left--;
                samples_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                    report_mismatch("result with nothing expected", '0, m_axis_tdata);
                else
                begin
                    logic [SAMPLE_W-1:0] want;
                    want = expected_out.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("sample_out mismatch", want, m_axis_tdata);
                    results_checked++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        logic [STEP_W-1:0] pitch_plan [8];
        pitch_plan = '{18'd65536, 18'd0, 18'h3FFFF, 18'd1, 18'd131072,
                       18'd0, 18'd0, 18'd32768};
        pitch_plan[5] = STEP_W'($urandom_range(0, 262143));
        pitch_plan[6] = STEP_W'($urandom_range(40000, 100000));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes at the reset pitch
        burst_mode = 1'b0;
        queue_sample(24'h000000);
        queue_sample(24'h7FFFFF);
        queue_sample(24'h800000);
        queue_sample(24'hFFFFFF);
        queue_sample(24'h000001);
        queue_sample(24'h555555);
        queue_sample(24'hAAAAAA);
        queue_sample(24'h7FFFFF);
        queue_sample(24'h800000);
        wait_quiet();

        // directed: largest step, read pointer wraps fast
        write_pitch(18'h3FFFF);
        queue_sample(24'h7FFFFF);
        queue_sample(24'h800000);
        queue_sample(24'h7FFFFF);
        queue_sample(24'h800000);
        queue_sample(24'h000000);
        queue_sample(24'hFFFFFF);
        wait_quiet();

        // directed: zero step, read pointer frozen
        write_pitch(18'd0);
        queue_sample(24'h800000);
        queue_sample(24'h7FFFFF);
        queue_sample(24'h123456);
        queue_sample(24'hEDCBA9);
        wait_quiet();

        // random phases, one pitch setting each, some with no idling at all
        for (int p = 0; p < 8; p++)
        begin
            write_pitch(pitch_plan[p]);
            burst_mode = (p % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_sample(rand_sample());
            wait_quiet();
        end
        burst_mode = 1'b0;
        wait_quiet();

        $display("checked %0d results from %0d samples over %0d pitch settings",
                 results_checked, samples_sent, pitch_settings + 1);
        $display("steps included zero, unity, double and the 18-bit maximum");
        if (error_count == 0 && expected_out.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: sim.f
design/dtps_pkg.sv
design/dtps_ram.sv
design/dtps_hann_rom.sv
design/dtps_mac.sv
design/dual_tap_pitch_shifter_unit.sv
design/dtps_checker.sv
tb/tb_top.sv
